FILE: design/falu_pkg.sv
package falu_pkg;

  localparam int FRAC_BITS = 8;
  // dividend 2*(|a| << F) + |b| stays below 2^(33+F)
  localparam int DIV_W = 33 + FRAC_BITS;
  localparam int DEN_W = 33;

  typedef enum logic [2:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_MUL = 3'd2,
    ACT_DIV = 3'd3,
    ACT_MIN = 3'd4,
    ACT_MAX = 3'd5,
    ACT_INC = 3'd6,
    ACT_DEC = 3'd7
  } action_t;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               a_greater;
    logic               a_less;
    logic               a_equal;
    logic               divide_by_zero;
    logic               saturated;
  } rsp_t;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } clamp_t;

  // apply sign to a magnitude and clamp into 32-bit signed range
  function automatic clamp_t clamp_mag(input logic [63:0] m, input logic neg);
    clamp_t r;
    r.sat = 1'b0;
    if (neg) begin
      if (m > 64'h0000_0000_8000_0000) begin
        r.sat = 1'b1;
        r.val = 32'h8000_0000;
      end else begin
        r.val = 32'd0 - m[31:0];
      end
    end else begin
      if (m > 64'h0000_0000_7fff_ffff) begin
        r.sat = 1'b1;
        r.val = 32'h7fff_ffff;
      end else begin
        r.val = m[31:0];
      end
    end
    return r;
  endfunction

endpackage

FILE: design/fixed_point_alu_q24_8_unit.sv
// path from an accepted start to the done strobe: input register, the pipelined
// divider (one quotient bit per stage, 33 + FRAC_BITS stages), output register
// throughput: one beat per cycle for every action; busy is never raised
// reset: rst clears all valid bits; results in flight are dropped
// the receiver cannot stall, each result shows for exactly one cycle
module fixed_point_alu_q24_8_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  falu_pkg::cmd_t  cmd,
  output logic            done,
  output falu_pkg::rsp_t  rsp
);
  import falu_pkg::*;

  localparam int MUL_LINE = DIV_W - 2;

  typedef struct packed {
    logic        vld;
    logic [2:0]  action;
    logic [31:0] simple;
    logic        simple_sat;
    logic        gt;
    logic        lt;
    logic        eq;
    logic        dz;
    logic        qneg;
  } misc_t;

  typedef struct packed {
    logic [63:0] q;
    logic        neg;
  } mulq_t;

  // input register
  logic               v1;
  cmd_t               c1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    c1 <= cmd;
  end

  assign busy = 1'b0;

  // simple ops with 33-bit saturation
  logic signed [31:0] a1;
  logic signed [31:0] b1;
  logic signed [32:0] sum;
  logic signed [32:0] dif;
  logic signed [32:0] inc;
  logic signed [32:0] dec;
  logic signed [32:0] pick;
  misc_t              misc_in;

  assign a1  = c1.operand_a;
  assign b1  = c1.operand_b;
  assign sum = {a1[31], a1} + {b1[31], b1};
  assign dif = {a1[31], a1} - {b1[31], b1};
  assign inc = {a1[31], a1} + 33'sd1;
  assign dec = {a1[31], a1} - 33'sd1;

  always_comb begin
    misc_in.vld    = v1;
    misc_in.action = c1.action;
    misc_in.gt     = a1 > b1;
    misc_in.lt     = a1 < b1;
    misc_in.eq     = a1 == b1;
    misc_in.dz     = (c1.action == ACT_DIV) && (b1 == 32'sd0);
    misc_in.qneg   = a1[31] ^ b1[31];
    case (c1.action)
      ACT_ADD: pick = sum;
      ACT_SUB: pick = dif;
      ACT_INC: pick = inc;
      ACT_DEC: pick = dec;
      ACT_MIN: pick = (a1 < b1) ? {a1[31], a1} : {b1[31], b1};
      ACT_MAX: pick = (a1 > b1) ? {a1[31], a1} : {b1[31], b1};
      default: pick = '0;
    endcase
    if (pick[32] != pick[31]) begin
      misc_in.simple_sat = 1'b1;
      misc_in.simple     = pick[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      misc_in.simple_sat = 1'b0;
      misc_in.simple     = pick[31:0];
    end
  end

  // side line that keeps flags and simple results aligned with the divider
  misc_t misc_line [DIV_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_W; k++) misc_line[k] <= '0;
    end else begin
      misc_line[0] <= misc_in;
      for (int k = 1; k < DIV_W; k++) misc_line[k] <= misc_line[k-1];
    end
  end

  // divider operands: 2*(|a| << F) + |b| over 2*|b|
  logic [31:0]      mag_a;
  logic [31:0]      mag_b;
  logic [DIV_W-1:0] dvd;
  logic [DEN_W-1:0] dvs;
  logic             div_vld;
  logic [DIV_W-1:0] quo;

  assign mag_a = a1[31] ? 32'd0 - a1 : a1;
  assign mag_b = b1[31] ? 32'd0 - b1 : b1;
  assign dvd   = (DIV_W'(mag_a) << (FRAC_BITS + 1)) + DIV_W'(mag_b);
  assign dvs   = {mag_b, 1'b0};

  falu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v1),
    .dividend (dvd),
    .divisor  (dvs),
    .out_valid(div_vld),
    .quotient (quo)
  );

  // multiply: product, magnitude, rounding, then delay
  logic signed [63:0] prod;
  logic [63:0]        pmag;
  logic               pneg;
  logic               pneg2;
  mulq_t              mul_line [MUL_LINE];
  mulq_t              mul_rnd;

  always_comb begin
    mul_rnd.q   = (pmag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    mul_rnd.neg = pneg2;
  end

  always_ff @(posedge clk) begin
    prod  <= 64'(a1) * 64'(b1);
    pmag  <= prod[63] ? 64'd0 - prod : prod;
    pneg2 <= prod[63];
    mul_line[0] <= mul_rnd;
    for (int k = 1; k < MUL_LINE; k++) mul_line[k] <= mul_line[k-1];
  end

  assign pneg = mul_line[MUL_LINE-1].neg;

  // final select and clamp
  misc_t  tail;
  clamp_t cm;
  clamp_t cd;
  rsp_t   rsp_next;

  assign tail = misc_line[DIV_W-1];
  assign cm   = clamp_mag(mul_line[MUL_LINE-1].q, pneg);
  assign cd   = clamp_mag(64'(quo), tail.qneg);

  always_comb begin
    rsp_next.a_greater      = tail.gt;
    rsp_next.a_less         = tail.lt;
    rsp_next.a_equal        = tail.eq;
    rsp_next.divide_by_zero = tail.dz;
    case (tail.action)
      ACT_MUL: begin
        rsp_next.result    = cm.val;
        rsp_next.saturated = cm.sat;
      end
      ACT_DIV: begin
        rsp_next.result    = tail.dz ? 32'sd0 : cd.val;
        rsp_next.saturated = !tail.dz && cd.sat;
      end
      default: begin
        rsp_next.result    = tail.simple;
        rsp_next.saturated = tail.simple_sat;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tail.vld;
    end
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

  // checks
  a_div_align: assert property (@(posedge clk) disable iff (rst)
    div_vld == tail.vld)
    else $error("divider valid out of step with side line");

  a_flags_onehot: assert property (@(posedge clk) disable iff (rst)
    done |-> $onehot({rsp.a_greater, rsp.a_less, rsp.a_equal}))
    else $error("compare flags not one-hot");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    done && rsp.divide_by_zero |-> rsp.result == 32'sd0 && !rsp.saturated)
    else $error("zero divisor beat not zero");

  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    done && rsp.saturated |->
      rsp.result == 32'sh7fff_ffff || rsp.result == 32'sh8000_0000)
    else $error("saturated beat not at a bound");

endmodule

FILE: design/falu_div.sv
module falu_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [falu_pkg::DIV_W-1:0] dividend,
  input  logic [falu_pkg::DEN_W-1:0] divisor,
  output logic                       out_valid,
  output logic [falu_pkg::DIV_W-1:0] quotient
);
  import falu_pkg::*;

  // one quotient bit per stage; the dividend register fills with quotient bits
  logic [DIV_W-1:0] dq  [DIV_W];
  logic [DEN_W-1:0] rem [DIV_W];
  logic [DEN_W-1:0] den [DIV_W];
  logic             vld [DIV_W];

  genvar i;
  generate
    for (i = 0; i < DIV_W; i++) begin : g_stage
      logic [DIV_W-1:0] dq_in;
      logic [DEN_W-1:0] rem_in;
      logic [DEN_W-1:0] den_in;
      logic             vld_in;
      logic [DEN_W:0]   trial;
      logic             fits;

      if (i == 0) begin : g_first
        assign dq_in  = dividend;
        assign rem_in = '0;
        assign den_in = divisor;
        assign vld_in = in_valid;
      end else begin : g_next
        assign dq_in  = dq[i-1];
        assign rem_in = rem[i-1];
        assign den_in = den[i-1];
        assign vld_in = vld[i-1];
      end

      // trial subtract of the shifted partial remainder
      assign trial = {rem_in, dq_in[DIV_W-1]};
      assign fits  = trial >= {1'b0, den_in};

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[i] <= 1'b0;
        end else begin
          vld[i] <= vld_in;
        end
      end

      always_ff @(posedge clk) begin
        dq[i]  <= {dq_in[DIV_W-2:0], fits};
        rem[i] <= fits ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
        den[i] <= den_in;
      end
    end
  endgenerate

  assign out_valid = vld[DIV_W-1];
  assign quotient  = dq[DIV_W-1];

endmodule

FILE: bench/fixed_point_alu_q24_8_unit_tb.sv
module fixed_point_alu_q24_8_unit_tb;
  import falu_pkg::*;

  localparam int LATENCY = 43;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BEATS = 1930;

  // expected results in order of issue, checked against each done beat
  class alu_scoreboard;
    rsp_t pending[$];
    int   errors;

    function new();
      errors = 0;
    endfunction

    // exact fixed-point behavior of one command
    function rsp_t predict(cmd_t c);
      rsp_t r;
      logic signed [63:0] a;
      logic signed [63:0] b;
      logic signed [63:0] wide;
      logic signed [63:0] prod;
      logic [63:0] mag;
      logic [63:0] num;
      logic [63:0] den;
      logic neg;
      a = c.operand_a;
      b = c.operand_b;
      r = '0;
      r.a_greater = a > b;
      r.a_less = a < b;
      r.a_equal = a == b;
      wide = 0;
      case (action_t'(c.action))
        ACT_ADD: wide = a + b;
        ACT_SUB: wide = a - b;
        ACT_MUL: begin
          prod = a * b;
          neg = prod < 0;
          mag = neg ? -prod : prod;
          mag = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
          wide = neg ? -$signed(mag) : $signed(mag);
        end
        ACT_DIV: begin
          if (b == 0) r.divide_by_zero = 1'b1;
          else begin
            num = (a < 0 ? -a : a) << FRAC_BITS;
            den = b < 0 ? -b : b;
            mag = (2 * num + den) / (2 * den);
            wide = ((a < 0) != (b < 0)) ? -$signed(mag) : $signed(mag);
          end
        end
        ACT_MIN: wide = (a < b) ? a : b;
        ACT_MAX: wide = (a > b) ? a : b;
        ACT_INC: wide = a + 1;
        default: wide = a - 1;
      endcase
      if (wide > 64'sd2147483647) begin
        wide = 64'sd2147483647;
        r.saturated = 1'b1;
      end else if (wide < -64'sd2147483648) begin
        wide = -64'sd2147483648;
        r.saturated = 1'b1;
      end
      r.result = wide[31:0];
      return r;
    endfunction

    function void note_command(cmd_t c);
      pending.push_back(predict(c));
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.result !== want.result)
        $display("%0t: result exp %h got %h", $time, want.result, got.result);
      if (got.a_greater !== want.a_greater)
        $display("%0t: a_greater exp %b got %b", $time, want.a_greater, got.a_greater);
      if (got.a_less !== want.a_less)
        $display("%0t: a_less exp %b got %b", $time, want.a_less, got.a_less);
      if (got.a_equal !== want.a_equal)
        $display("%0t: a_equal exp %b got %b", $time, want.a_equal, got.a_equal);
      if (got.divide_by_zero !== want.divide_by_zero)
        $display("%0t: divide_by_zero exp %b got %b", $time,
                 want.divide_by_zero, got.divide_by_zero);
      if (got.saturated !== want.saturated)
        $display("%0t: saturated exp %b got %b", $time, want.saturated, got.saturated);
      if (got !== want) errors++;
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  cmd_t cmd;
  logic done;
  rsp_t rsp;
  alu_scoreboard board;
  int idle_cycles;
  int burst_left;

  fixed_point_alu_q24_8_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .done(done), .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result sampling and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (done) board.check_result(rsp);
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("** fixed_point_alu_q24_8_unit: FAILED **");
        $finish;
      end
    end
  end

  // issue one command beat, with bursts and random gaps before it
  task automatic send_beat(cmd_t c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_command(c);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff - $urandom_range(0, 2);
      1: return 32'h8000_0000 + $urandom_range(0, 2);
      2: return $urandom_range(0, 4) - 2;
      3: return $signed($urandom_range(0, 4096)) - 2048;
      4: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_cmd(action_t op, logic [31:0] a, logic [31:0] b);
    cmd_t c;
    c.action = op;
    c.operand_a = a;
    c.operand_b = b;
    send_beat(c);
  endtask

  initial begin
    cmd_t c;
    int waited;
    board = new();
    idle_cycles = 0;
    burst_left = 0;
    rst <= 1'b1;
    start <= 1'b0;
    cmd <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed corners
    send_cmd(ACT_ADD, 32'h7fff_ffff, 32'h0000_0001);
    send_cmd(ACT_ADD, 32'h8000_0000, 32'hffff_ffff);
    send_cmd(ACT_SUB, 32'h8000_0000, 32'h0000_0001);
    send_cmd(ACT_SUB, 32'h7fff_ffff, 32'h8000_0000);
    send_cmd(ACT_MUL, 32'h8000_0000, 32'h8000_0000);
    send_cmd(ACT_MUL, 32'h0000_0180, 32'hffff_ff80);
    send_cmd(ACT_MUL, 32'h0000_0001, 32'h0000_0080);
    send_cmd(ACT_MUL, 32'h7fff_ffff, 32'h8000_0000);
    send_cmd(ACT_DIV, 32'h0000_1234, 32'h0000_0000);
    send_cmd(ACT_DIV, 32'h8000_0000, 32'h0000_0001);
    send_cmd(ACT_DIV, 32'h8000_0000, 32'h8000_0000);
    send_cmd(ACT_DIV, 32'h0000_0001, 32'h0000_0200);
    send_cmd(ACT_DIV, 32'hffff_ffff, 32'h0000_0200);
    send_cmd(ACT_DIV, 32'h7fff_ffff, 32'hffff_ffff);
    send_cmd(ACT_MIN, 32'h8000_0000, 32'h7fff_ffff);
    send_cmd(ACT_MIN, 32'h0000_0005, 32'h0000_0005);
    send_cmd(ACT_MAX, 32'h8000_0000, 32'h7fff_ffff);
    send_cmd(ACT_MAX, 32'hffff_fff0, 32'hffff_fff0);
    send_cmd(ACT_INC, 32'h7fff_ffff, 32'h0000_0000);
    send_cmd(ACT_INC, 32'hffff_ffff, 32'hffff_ffff);
    send_cmd(ACT_DEC, 32'h8000_0000, 32'h0000_0000);
    send_cmd(ACT_DEC, 32'h0000_0000, 32'h8000_0000);

    // random commands, equal operands now and then
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      c.action = 3'($urandom_range(0, 7));
      c.operand_a = pick_operand();
      c.operand_b = ($urandom_range(0, 15) == 0) ? c.operand_a : pick_operand();
      send_beat(c);
    end
    start <= 1'b0;

    // drain
    waited = 0;
    while (board.pending.size() > 0 && waited < 10 * LATENCY) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("** fixed_point_alu_q24_8_unit: PASSED **");
    else
      $display("** fixed_point_alu_q24_8_unit: FAILED **");
    $finish;
  end

endmodule
